>>> src/sfhn_pkg.sv
// ----------------------------------------------------------------------------
// sfhn_pkg
// Shared types and constants for the stochastic FitzHugh-Nagumo step block.
// ----------------------------------------------------------------------------
package sfhn_pkg;

    // Default state width and fixed-point layout
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FRAC_BITS       = 13;  // Q3.13 values
    localparam int RATE_BITS       = 16;  // Q0.16 recovery rate
    localparam int SQ_WIDTH        = 30;  // square term saturates to this many bits
    localparam int FIELD_WIDTH     = 16;  // width of every config and stream field

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [FIELD_WIDTH-1:0] THRESHOLD_A_RST   = 16'd410;    // 0.05
    localparam logic [FIELD_WIDTH-1:0] PEAK_LEVEL_RST    = 16'd8192;   // 1.0
    localparam logic [FIELD_WIDTH-1:0] RECOVERY_GAIN_RST = 16'd24576;  // 3.0
    localparam logic [FIELD_WIDTH-1:0] RECOVERY_RATE_RST = 16'd328;    // 0.005
    localparam logic [FIELD_WIDTH-1:0] START_V_RST       = 16'd0;
    localparam logic [FIELD_WIDTH-1:0] START_N_RST       = 16'd0;

    typedef enum logic [2:0] {
        REG_THRESHOLD_A   = 3'd0,
        REG_PEAK_LEVEL    = 3'd1,
        REG_RECOVERY_GAIN = 3'd2,
        REG_RECOVERY_RATE = 3'd3,
        REG_START_V       = 3'd4,
        REG_START_N       = 3'd5
    } cfg_reg_t;

    // Item command carried in tuser
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] threshold_a;
        logic signed [FIELD_WIDTH-1:0] peak_level;
        logic signed [FIELD_WIDTH-1:0] recovery_gain;
        logic        [FIELD_WIDTH-1:0] recovery_rate;
        logic signed [FIELD_WIDTH-1:0] start_v;
        logic signed [FIELD_WIDTH-1:0] start_n;
    } cfg_t;

    // Which product the shared multiplier forms, and which earlier product is captured
    typedef enum logic [1:0] {
        OP_GN,     // gamma * N
        OP_SQ,     // V * (V - a); capture gamma*N
        OP_RATE,   // eps * (V - gN); capture square term
        OP_CUBIC   // sq * (vmax - V); capture new N
    } mul_op_t;

    typedef struct packed {
        logic    capture;  // latch input payload
        logic    mul_en;   // run the multiplier this cycle
        mul_op_t op;
        logic    finish;   // commit state and load the output register
        logic    restart;  // item is a restart
    } dp_cmd_t;

endpackage

>>> src/stochastic_fhn_neuron_step.sv
// ----------------------------------------------------------------------------
// stochastic_fhn_neuron_step
// One unit Euler step of a FitzHugh-Nagumo neuron with additive noise.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------
//  s_*     | in        | s_tvalid / s_tready  | tdata: current, noise_v, noise_n;
//          |           |                      | tuser: command
//  m_*     | out       | m_tvalid / m_tready  | tdata: membrane_v, recovery_n;
//          |           |                      | tuser: saturated
//  APB     | in        | psel/penable, pready | six 16-bit coefficient registers
//
//  An advance transaction steps through the four multiplier states, then the
//  commit state, which loads the output register once it is free; a restart
//  goes from idle straight to commit. The next transaction is taken only back
//  in idle. The schedule is set by the single shared multiplier, which forms
//  gamma*N, V*(V-a), eps*(V-gN) and sq*(vmax-V) in turn.
//  The block takes one transaction at a time; a new one is accepted while
//  the previous result still waits in the output register.
//  When the output is stalled at commit, hold the sequencer until it drains.
//  Reset clears V, N and the registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module stochastic_fhn_neuron_step
#(
    parameter int VALUE_WIDTH = sfhn_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfhn_pkg::CFG_AW-1:0] paddr,
    input  logic [sfhn_pkg::CFG_DW-1:0] pwdata,
    output logic [sfhn_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,

    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,  // [15:0] stimulus_current,
                                                  // [31:16] noise_v, [47:32] noise_n
    input  logic [0:0]                  s_tuser,  // [0] command

    // Output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // [15:0] membrane_v, [31:16] recovery_n
    output logic [0:0]                  m_tuser   // [0] saturated
);

    localparam int FW = sfhn_pkg::FIELD_WIDTH;

    sfhn_pkg::cfg_t    cfg;
    sfhn_pkg::dp_cmd_t cmd;

    logic signed [FW-1:0] membrane_v;
    logic signed [FW-1:0] recovery_n;
    logic                 saturated;

    // Coefficient registers
    sfhn_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: accepts a transaction, walks the multiplier schedule,
    // commits when the output register is free
    sfhn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic, neuron state and output register
    sfhn_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg),
        .stimulus_current (s_tdata[15:0]),
        .noise_v          (s_tdata[31:16]),
        .noise_n          (s_tdata[47:32]),
        .membrane_v       (membrane_v),
        .recovery_n       (recovery_n),
        .saturated        (saturated)
    );

    assign m_tdata = {recovery_n, membrane_v};
    assign m_tuser = saturated;

endmodule

>>> src/sfhn_cfg.sv
// ----------------------------------------------------------------------------
// sfhn_cfg
// APB-style register file holding the model coefficients and start values.
// ----------------------------------------------------------------------------
module sfhn_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfhn_pkg::CFG_AW-1:0]   paddr,
    input  logic [sfhn_pkg::CFG_DW-1:0]   pwdata,
    output logic [sfhn_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output sfhn_pkg::cfg_t                cfg
);

    sfhn_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;
    logic [sfhn_pkg::FIELD_WIDTH-1:0] wr_val;
    logic [sfhn_pkg::FIELD_WIDTH-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sfhn_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_val  = pwdata[sfhn_pkg::FIELD_WIDTH-1:0];

    always_comb
    begin
        unique case (reg_idx)
            sfhn_pkg::REG_THRESHOLD_A:   rd_val = cfg_reg.threshold_a;
            sfhn_pkg::REG_PEAK_LEVEL:    rd_val = cfg_reg.peak_level;
            sfhn_pkg::REG_RECOVERY_GAIN: rd_val = cfg_reg.recovery_gain;
            sfhn_pkg::REG_RECOVERY_RATE: rd_val = cfg_reg.recovery_rate;
            sfhn_pkg::REG_START_V:       rd_val = cfg_reg.start_v;
            sfhn_pkg::REG_START_N:       rd_val = cfg_reg.start_n;
            default:                     rd_val = '0;
        endcase
    end

    assign prdata = {{(sfhn_pkg::CFG_DW - sfhn_pkg::FIELD_WIDTH){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_a   <= sfhn_pkg::THRESHOLD_A_RST;
            cfg_reg.peak_level    <= sfhn_pkg::PEAK_LEVEL_RST;
            cfg_reg.recovery_gain <= sfhn_pkg::RECOVERY_GAIN_RST;
            cfg_reg.recovery_rate <= sfhn_pkg::RECOVERY_RATE_RST;
            cfg_reg.start_v       <= sfhn_pkg::START_V_RST;
            cfg_reg.start_n       <= sfhn_pkg::START_N_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sfhn_pkg::REG_THRESHOLD_A:   cfg_reg.threshold_a   <= wr_val;
                sfhn_pkg::REG_PEAK_LEVEL:    cfg_reg.peak_level    <= wr_val;
                sfhn_pkg::REG_RECOVERY_GAIN: cfg_reg.recovery_gain <= wr_val;
                sfhn_pkg::REG_RECOVERY_RATE: cfg_reg.recovery_rate <= wr_val;
                sfhn_pkg::REG_START_V:       cfg_reg.start_v       <= wr_val;
                sfhn_pkg::REG_START_N:       cfg_reg.start_n       <= wr_val;
                default:                     ;
            endcase
        end
    end

endmodule

>>> src/sfhn_ctrl.sv
// ----------------------------------------------------------------------------
// sfhn_ctrl
// Sequencer: steps the shared multiplier through the four products of one
// Euler step and owns the output valid.
// ----------------------------------------------------------------------------
module sfhn_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               command,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sfhn_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GN,
        S_SQ,
        S_RATE,
        S_CUBIC,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   restart_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd.capture = accept;
        cmd.restart = restart_reg;
        cmd.finish  = (state_reg == S_FIN) && out_free;
        cmd.mul_en  = 1'b0;
        cmd.op      = sfhn_pkg::OP_GN;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (command == sfhn_pkg::CMD_RESTART) ? S_FIN : S_GN;
            end
            S_GN:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = sfhn_pkg::OP_GN;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = sfhn_pkg::OP_SQ;
                state_next = S_RATE;
            end
            S_RATE:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = sfhn_pkg::OP_RATE;
                state_next = S_CUBIC;
            end
            S_CUBIC:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = sfhn_pkg::OP_CUBIC;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            restart_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                restart_reg <= (command == sfhn_pkg::CMD_RESTART);
            if (cmd.finish)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // An advance item reaches commit after the four multiplier states
    a_advance_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == sfhn_pkg::CMD_ADVANCE) |-> ##5 (state_reg == S_FIN))
        else $error("advance item did not reach commit on schedule");

    a_restart_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == sfhn_pkg::CMD_RESTART) |=> (state_reg == S_FIN))
        else $error("restart item did not go straight to commit");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(cmd.finish))
        else $error("output valid raised without a commit");

endmodule

>>> src/sfhn_dp.sv
// ----------------------------------------------------------------------------
// sfhn_dp
// Datapath: neuron state, one shared signed multiplier with its product
// register, intermediate terms, saturation and the output register.
// ----------------------------------------------------------------------------
module sfhn_dp
#(
    parameter int VALUE_WIDTH = sfhn_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sfhn_pkg::dp_cmd_t                       cmd,
    input  sfhn_pkg::cfg_t                          cfg,
    input  logic signed [sfhn_pkg::FIELD_WIDTH-1:0] stimulus_current,
    input  logic signed [sfhn_pkg::FIELD_WIDTH-1:0] noise_v,
    input  logic signed [sfhn_pkg::FIELD_WIDTH-1:0] noise_n,
    output logic signed [sfhn_pkg::FIELD_WIDTH-1:0] membrane_v,
    output logic signed [sfhn_pkg::FIELD_WIDTH-1:0] recovery_n,
    output logic                                    saturated
);

    localparam int W   = VALUE_WIDTH;
    localparam int FW  = sfhn_pkg::FIELD_WIDTH;
    localparam int FB  = sfhn_pkg::FRAC_BITS;
    localparam int RB  = sfhn_pkg::RATE_BITS;
    localparam int SQW = sfhn_pkg::SQ_WIDTH;
    localparam int DW  = ((W > FW) ? W : FW) + 1;     // V - a, vmax - V
    localparam int XW  = (W > SQW) ? W : SQW;          // multiplier operand X
    localparam int D3W = W + 4;                        // V - gN
    localparam int YW  = (DW > D3W) ? DW : D3W;        // multiplier operand Y
    localparam int PW  = XW + YW;
    localparam int GNW = W + 3;                        // gamma*N >> 13
    localparam int RTW = W + 5;                        // eps*(V - gN) >> 16
    localparam int RNW = W + 6;                        // new N before clipping
    localparam int CW  = DW + SQW - FB;                // cubic term
    localparam int VSW = CW + 3;                       // new V before clipping

    logic signed [W-1:0]   v_reg, n_reg;
    logic signed [FW-1:0]  cur_reg, nv_reg, nn_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [GNW-1:0] gn_reg;
    logic signed [SQW-1:0] sq_reg;
    logic signed [RNW-1:0] rn_reg;
    logic signed [FW-1:0]  out_v_reg, out_n_reg;
    logic                  out_sat_reg;

    logic signed [DW-1:0]  d1, d2;
    logic signed [D3W-1:0] d3;
    logic signed [FW:0]    eps_s;
    logic signed [XW-1:0]  mul_x;
    logic signed [YW-1:0]  mul_y;
    logic signed [PW-1:0]  prod_next;
    logic signed [PW-1:0]  frac_sh, rate_sh;
    logic [PW-SQW:0]       sq_hi;
    logic signed [SQW-1:0] sq_next;
    logic signed [RNW-1:0] rn_next;
    logic signed [CW-1:0]  cubic;
    logic signed [VSW-1:0] vsum;
    logic [VSW-W:0]        vs_hi;
    logic [RNW-W:0]        rn_hi;
    logic signed [DW-1:0]  sv_ext, sn_ext;
    logic [DW-W:0]         sv_hi, sn_hi;
    logic                  v_fit, n_fit, sv_fit, sn_fit;
    logic signed [W-1:0]   v_step, n_step, v_start, n_start, v_fin, n_fin;
    logic                  sat_fin;

    // Operands
    assign d1    = DW'(v_reg) - DW'(cfg.threshold_a);
    assign d2    = DW'(cfg.peak_level) - DW'(v_reg);
    assign d3    = D3W'(v_reg) - D3W'(gn_reg);
    assign eps_s = $signed({1'b0, cfg.recovery_rate});

    always_comb
    begin
        unique case (cmd.op)
            sfhn_pkg::OP_GN:
            begin
                mul_x = XW'(cfg.recovery_gain);
                mul_y = YW'(n_reg);
            end
            sfhn_pkg::OP_SQ:
            begin
                mul_x = XW'(v_reg);
                mul_y = YW'(d1);
            end
            sfhn_pkg::OP_RATE:
            begin
                mul_x = XW'(eps_s);
                mul_y = YW'(d3);
            end
            sfhn_pkg::OP_CUBIC:
            begin
                mul_x = XW'(sq_reg);
                mul_y = YW'(d2);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_x) * PW'(mul_y);

    // Arithmetic shifts floor toward minus infinity
    assign frac_sh = prod_reg >>> FB;
    assign rate_sh = prod_reg >>> RB;

    // Square term saturates to SQW bits
    assign sq_hi   = frac_sh[PW-1:SQW-1];
    assign sq_next = ((&sq_hi) || !(|sq_hi)) ? frac_sh[SQW-1:0]
                                            : {frac_sh[PW-1], {(SQW-1){~frac_sh[PW-1]}}};

    assign rn_next = RNW'(n_reg) + RNW'($signed(rate_sh[RTW-1:0]));
    assign cubic   = $signed(frac_sh[CW-1:0]);
    assign vsum    = VSW'(v_reg) + VSW'(cur_reg) + VSW'(cubic) + VSW'(nv_reg)
                   - VSW'(n_reg) - VSW'(nn_reg);

    // Saturate to the state width
    assign vs_hi  = vsum[VSW-1:W-1];
    assign v_fit  = (&vs_hi) || !(|vs_hi);
    assign v_step = v_fit ? vsum[W-1:0] : {vsum[VSW-1], {(W-1){~vsum[VSW-1]}}};

    assign rn_hi  = rn_reg[RNW-1:W-1];
    assign n_fit  = (&rn_hi) || !(|rn_hi);
    assign n_step = n_fit ? rn_reg[W-1:0] : {rn_reg[RNW-1], {(W-1){~rn_reg[RNW-1]}}};

    assign sv_ext  = DW'(cfg.start_v);
    assign sv_hi   = sv_ext[DW-1:W-1];
    assign sv_fit  = (&sv_hi) || !(|sv_hi);
    assign v_start = sv_fit ? sv_ext[W-1:0] : {sv_ext[DW-1], {(W-1){~sv_ext[DW-1]}}};

    assign sn_ext  = DW'(cfg.start_n);
    assign sn_hi   = sn_ext[DW-1:W-1];
    assign sn_fit  = (&sn_hi) || !(|sn_hi);
    assign n_start = sn_fit ? sn_ext[W-1:0] : {sn_ext[DW-1], {(W-1){~sn_ext[DW-1]}}};

    assign v_fin   = cmd.restart ? v_start : v_step;
    assign n_fin   = cmd.restart ? n_start : n_step;
    assign sat_fin = cmd.restart ? !(sv_fit && sn_fit) : !(v_fit && n_fit);

    // Neuron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            n_reg <= '0;
        end
        else if (cmd.finish)
        begin
            v_reg <= v_fin;
            n_reg <= n_fin;
        end
    end

    // Payload and intermediates
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg <= stimulus_current;
            nv_reg  <= noise_v;
            nn_reg  <= noise_n;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
            unique case (cmd.op)
                sfhn_pkg::OP_GN:    ;
                sfhn_pkg::OP_SQ:    gn_reg <= frac_sh[GNW-1:0];
                sfhn_pkg::OP_RATE:  sq_reg <= sq_next;
                sfhn_pkg::OP_CUBIC: rn_reg <= rn_next;
                default:            ;
            endcase
        end
        if (cmd.finish)
        begin
            out_v_reg   <= FW'(v_fin);
            out_n_reg   <= FW'(n_fin);
            out_sat_reg <= sat_fin;
        end
    end

    assign membrane_v = out_v_reg;
    assign recovery_n = out_n_reg;
    assign saturated  = out_sat_reg;

endmodule

>>> verif/sfhn_step_checker.sv
// ----------------------------------------------------------------------------
// sfhn_step_checker
// Watches the configuration port and both streams of the FitzHugh-Nagumo
// step block, predicts every result from its own copy of the neuron state
// and coefficients, and compares each result field by field.
// ----------------------------------------------------------------------------
module sfhn_step_checker
#(
    parameter int VALUE_WIDTH = sfhn_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [sfhn_pkg::CFG_AW-1:0] paddr,
    input  logic [sfhn_pkg::CFG_DW-1:0] pwdata,

    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [47:0]                 s_tdata,  // [15:0] stimulus_current,
                                                  // [31:16] noise_v, [47:32] noise_n
    input  logic [0:0]                  s_tuser,  // [0] command

    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [31:0]                 m_tdata,  // [15:0] membrane_v, [31:16] recovery_n
    input  logic [0:0]                  m_tuser,  // [0] saturated

    output int                          fail_count,
    output int                          pending,
    output int                          results_seen,
    output int                          clipped_seen
);

    localparam int FW = sfhn_pkg::FIELD_WIDTH;

    typedef struct packed {
        logic signed [FW-1:0] membrane;
        logic signed [FW-1:0] recovery;
        logic                 clipped;
    } neuron_result_t;

    logic signed [FW-1:0] thresh_q   = sfhn_pkg::THRESHOLD_A_RST;
    logic signed [FW-1:0] peak_q     = sfhn_pkg::PEAK_LEVEL_RST;
    logic signed [FW-1:0] gain_q     = sfhn_pkg::RECOVERY_GAIN_RST;
    logic        [FW-1:0] rate_q     = sfhn_pkg::RECOVERY_RATE_RST;
    logic signed [FW-1:0] start_v_q  = sfhn_pkg::START_V_RST;
    logic signed [FW-1:0] start_n_q  = sfhn_pkg::START_N_RST;

    longint membrane_q = 0;
    longint recovery_q = 0;

    neuron_result_t expected_states[$];
    int fails   = 0;
    int results = 0;
    int clips   = 0;

    function automatic longint saturate(input longint x, input longint hi, inout logic hit);
        if (x > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (x < -hi - 1)
        begin
            hit = 1'b1;
            return -hi - 1;
        end
        return x;
    endfunction

    // Advance the neuron copy by one transaction and return what the block must emit
    function automatic neuron_result_t step_neuron(input logic cmd,
                                                   input logic signed [FW-1:0] cur,
                                                   input logic signed [FW-1:0] noise_v,
                                                   input logic signed [FW-1:0] noise_n);
        longint v, n, a, vmax, gam, eps, sq, cubic, gn, v_next, n_next, lim;
        logic hit, sq_hit;
        neuron_result_t r;
        lim    = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
        hit    = 1'b0;
        sq_hit = 1'b0;
        v      = membrane_q;
        n      = recovery_q;
        if (cmd == sfhn_pkg::CMD_RESTART)
        begin
            v_next = start_v_q;
            n_next = start_n_q;
        end
        else
        begin
            a    = thresh_q;
            vmax = peak_q;
            gam  = gain_q;
            eps  = rate_q;
            sq   = (v * (v - a)) >>> sfhn_pkg::FRAC_BITS;
            sq   = saturate(sq, (longint'(1) <<< (sfhn_pkg::SQ_WIDTH - 1)) - 1, sq_hit);
            cubic  = (sq * (vmax - v)) >>> sfhn_pkg::FRAC_BITS;
            v_next = v + cur + cubic + noise_v - n - noise_n;
            gn     = (gam * n) >>> sfhn_pkg::FRAC_BITS;
            n_next = n + ((eps * (v - gn)) >>> sfhn_pkg::RATE_BITS);
        end
        membrane_q = saturate(v_next, lim, hit);
        recovery_q = saturate(n_next, lim, hit);
        r.membrane = membrane_q[FW-1:0];
        r.recovery = recovery_q[FW-1:0];
        r.clipped  = hit;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        neuron_result_t want;
        logic signed [FW-1:0] got_v, got_n;
        if (!rst_n)
        begin
            thresh_q   = sfhn_pkg::THRESHOLD_A_RST;
            peak_q     = sfhn_pkg::PEAK_LEVEL_RST;
            gain_q     = sfhn_pkg::RECOVERY_GAIN_RST;
            rate_q     = sfhn_pkg::RECOVERY_RATE_RST;
            start_v_q  = sfhn_pkg::START_V_RST;
            start_n_q  = sfhn_pkg::START_N_RST;
            membrane_q = 0;
            recovery_q = 0;
            expected_states.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (sfhn_pkg::cfg_reg_t'(paddr[sfhn_pkg::CFG_AW-1:2]))
                    sfhn_pkg::REG_THRESHOLD_A:   thresh_q  = pwdata[FW-1:0];
                    sfhn_pkg::REG_PEAK_LEVEL:    peak_q    = pwdata[FW-1:0];
                    sfhn_pkg::REG_RECOVERY_GAIN: gain_q    = pwdata[FW-1:0];
                    sfhn_pkg::REG_RECOVERY_RATE: rate_q    = pwdata[FW-1:0];
                    sfhn_pkg::REG_START_V:       start_v_q = pwdata[FW-1:0];
                    sfhn_pkg::REG_START_N:       start_n_q = pwdata[FW-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                expected_states.insert(expected_states.size(),
                                       step_neuron(s_tuser[0], s_tdata[15:0],
                                                   s_tdata[31:16], s_tdata[47:32]));

            if (m_tvalid && m_tready)
            begin
                results++;
                if (m_tuser[0])
                    clips++;
                got_v = m_tdata[15:0];
                got_n = m_tdata[31:16];
                if (expected_states.size() == 0)
                begin
                    $error("unexpected result: membrane_v %0d, recovery_n %0d", got_v, got_n);
                    fails++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (got_v !== want.membrane)
                    begin
                        $error("membrane_v: expected %0d, actual %0d", want.membrane, got_v);
                        fails++;
                    end
                    if (got_n !== want.recovery)
                    begin
                        $error("recovery_n: expected %0d, actual %0d", want.recovery, got_n);
                        fails++;
                    end
                    if (m_tuser[0] !== want.clipped)
                    begin
                        $error("saturated: expected %0b, actual %0b", want.clipped, m_tuser[0]);
                        fails++;
                    end
                end
            end
        end
        fail_count   <= fails;
        pending      <= expected_states.size();
        results_seen <= results;
        clipped_seen <= clips;
    end

endmodule

>>> verif/stochastic_fhn_neuron_step_test.sv
// ----------------------------------------------------------------------------
// stochastic_fhn_neuron_step_test
// Drives the FitzHugh-Nagumo step block through its coefficient registers and
// its input stream, with random idling on both streams, and lets the checker
// compare every result; gives the pass or fail verdict at the end.
// ----------------------------------------------------------------------------
module stochastic_fhn_neuron_step_test;

    // Register settings used between phases
    typedef enum int {
        SET_DEFAULT,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_WILD,
        SET_MILD
    } setting_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;

    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [sfhn_pkg::CFG_AW-1:0]    paddr    = '0;
    logic [sfhn_pkg::CFG_DW-1:0]    pwdata   = '0;
    logic [sfhn_pkg::CFG_DW-1:0]    prdata;
    logic                           pready;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata  = '0;  // [15:0] current, [31:16] noise_v,
                                                    // [47:32] noise_n
    logic [0:0]                     s_tuser  = '0;  // [0] command

    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;        // [15:0] membrane_v, [31:16] recovery_n
    logic [0:0]                     m_tuser;        // [0] saturated

    // Quiet phases run with no idling on either stream
    logic                           quiet    = 1'b0;
    int                             stall_left = 0;

    int                             fail_count;
    int                             pending;
    int                             results_seen;
    int                             clipped_seen;

    int                             items_sent    = 0;
    int                             restarts_sent = 0;
    int                             settings_used = 0;

    stochastic_fhn_neuron_step dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sfhn_step_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .clipped_seen (clipped_seen)
    );

    // 12-unit clock period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Small signed value around zero, keeps the neuron in its useful range
    function automatic logic [15:0] near_zero(input int span);
        return 16'($urandom_range(0, 2 * span)) - 16'(span);
    endfunction

    // Output side: drop tready for random stretches unless the phase is quiet
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= idle_length();
        end
        else
            m_tready <= 1'b1;
    end

    // Send one transaction. Enter and leave at a rising edge; with no gap,
    // hold tvalid high straight into the next transaction.
    task automatic send_item(input logic cmd, input logic [15:0] cur,
                             input logic [15:0] noise_v, input logic [15:0] noise_n);
        int gap;
        gap = quiet ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {noise_n, noise_v, cur};
        s_tuser[0] <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (cmd == sfhn_pkg::CMD_RESTART)
            restarts_sent++;
    endtask

    // Drop tvalid and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    // One register write: setup phase, then access until pready
    task automatic write_reg(input sfhn_pkg::cfg_reg_t idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Load all six coefficient registers; call only while drained
    task automatic apply_setting(input setting_t kind);
        logic [15:0] vals [6];
        int i;
        case (kind)
            SET_DEFAULT:
            begin
                vals[0] = sfhn_pkg::THRESHOLD_A_RST;
                vals[1] = sfhn_pkg::PEAK_LEVEL_RST;
                vals[2] = sfhn_pkg::RECOVERY_GAIN_RST;
                vals[3] = sfhn_pkg::RECOVERY_RATE_RST;
                vals[4] = near_zero(8192);
                vals[5] = near_zero(2048);
            end
            SET_ALL_MAX:
            begin
                for (i = 0; i < 6; i++)
                    vals[i] = 16'h7FFF;
                vals[sfhn_pkg::REG_RECOVERY_RATE] = 16'hFFFF;
            end
            SET_ALL_MIN:
            begin
                for (i = 0; i < 6; i++)
                    vals[i] = 16'h8000;
                vals[sfhn_pkg::REG_RECOVERY_RATE] = 16'h0000;
            end
            SET_WILD:
            begin
                for (i = 0; i < 6; i++)
                    vals[i] = 16'($urandom);
            end
            default:
            begin
                vals[0] = 16'($urandom_range(0, 1600));
                vals[1] = 16'($urandom_range(6000, 10000));
                vals[2] = 16'($urandom_range(8192, 32767));
                vals[3] = 16'($urandom_range(100, 2000));
                vals[4] = near_zero(16384);
                vals[5] = near_zero(8192);
            end
        endcase
        for (i = 0; i < 6; i++)
            write_reg(sfhn_pkg::cfg_reg_t'(3'(i)), vals[i]);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int r;
        int phase;
        int k;
        setting_t kind;

        // Hold reset, then release it on a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset coefficients, zero state, field extremes
        send_item(sfhn_pkg::CMD_RESTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h7FFF, 16'h0000, 16'h0000);  // lands exactly on the top rail
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h8000, 16'h8000, 16'h0000);  // clip low
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h0000, 16'h7FFF, 16'h7FFF);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'h8000);
        send_item(sfhn_pkg::CMD_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // payload ignored
        send_item(sfhn_pkg::CMD_ADVANCE, 16'd2000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'd2000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'd2000, 16'h0000, 16'h0000);
        drain();

        // Directed: every register at its top, restart into the rails
        apply_setting(SET_ALL_MAX);
        send_item(sfhn_pkg::CMD_RESTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(sfhn_pkg::CMD_RESTART, 16'h1234, 16'h0000, 16'hFFFF);
        drain();

        // Directed: every register at its bottom
        apply_setting(SET_ALL_MIN);
        send_item(sfhn_pkg::CMD_RESTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'h0000);
        send_item(sfhn_pkg::CMD_ADVANCE, 16'h7FFF, 16'h7FFF, 16'h8000);

        // Random phases: new coefficients, restart, then a stream of steps
        for (phase = 0; phase < 9; phase++)
        begin
            drain();
            case (phase)
                0: kind = SET_DEFAULT;
                1: kind = SET_ALL_MAX;
                2: kind = SET_ALL_MIN;
                default:
                begin
                    r = $urandom_range(0, 9);
                    kind = (r < 6) ? SET_MILD : (r < 8) ? SET_WILD : SET_DEFAULT;
                end
            endcase
            apply_setting(kind);
            quiet <= ($urandom_range(0, 3) == 0);
            @(posedge clk);
            send_item(sfhn_pkg::CMD_RESTART, 16'($urandom), 16'($urandom),
                      16'($urandom));
            for (k = 0; k < 55; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_item(sfhn_pkg::CMD_RESTART, 16'($urandom), 16'($urandom),
                              16'($urandom));
                else if (r < 80)
                    send_item(sfhn_pkg::CMD_ADVANCE, near_zero(1500), near_zero(300),
                              near_zero(300));
                else
                    send_item(sfhn_pkg::CMD_ADVANCE, 16'($urandom), 16'($urandom),
                              16'($urandom));
            end
        end

        // Let the last results come home, then give the verdict
        drain();
        $display("Sent %0d transactions (%0d restarts) over %0d register settings.",
                 items_sent, restarts_sent, settings_used);
        $display("Checked %0d results, %0d of them with a clipped value.",
                 results_seen, clipped_seen);
        if (fail_count == 0 && pending == 0)
            $display("stochastic_fhn_neuron_step: match");
        else
            $display("stochastic_fhn_neuron_step: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("Timed out waiting for the block.");
        $display("stochastic_fhn_neuron_step: mismatch");
        $finish;
    end

endmodule
